// ===== src/ste_pkg.sv =====
// shared widths, item record and bounds for the segment crossing pipeline
package ste_pkg;

  localparam int CoordWidth = 32;
  // segment deltas, products, cross-product terms
  localparam int SW  = CoordWidth + 1;
  localparam int PW  = 2 * SW;
  localparam int DW  = PW + 1;
  // split of the tn magnitude for the wide multiply
  localparam int TL  = DW / 2;
  localparam int TH  = DW - TL;
  // numerator magnitude, doubled-and-biased numerator, doubled divisor
  localparam int NM  = SW + DW;
  localparam int N2W = NM + 2;
  localparam int D2W = DW + 1;
  localparam int RW  = D2W;
  localparam int XW  = CoordWidth + 2;

  localparam logic signed [XW-1:0] CoordMax = {3'b000, {(CoordWidth-1){1'b1}}};
  localparam logic signed [XW-1:0] CoordMin = {3'b111, {(CoordWidth-1){1'b0}}};

  typedef struct packed {
    logic signed [CoordWidth-1:0] p0x;
    logic signed [CoordWidth-1:0] p0y;
    logic signed [CoordWidth-1:0] z;
    logic                         on_both;
    logic                         parallel;
    logic                         neg_x;
    logic                         neg_y;
  } item_t;

endpackage

// ===== src/ste_front.sv =====
// deltas, cross products, sign normalization and segment range test
module ste_front import ste_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [CoordWidth-1:0] fs_x,
  input  logic signed [CoordWidth-1:0] fs_y,
  input  logic signed [CoordWidth-1:0] fe_x,
  input  logic signed [CoordWidth-1:0] fe_y,
  input  logic signed [CoordWidth-1:0] ss_x,
  input  logic signed [CoordWidth-1:0] ss_y,
  input  logic signed [CoordWidth-1:0] se_x,
  input  logic signed [CoordWidth-1:0] se_y,
  input  logic signed [CoordWidth-1:0] hz,
  output logic                         f_valid,
  output item_t                        f_item,
  output logic        [SW-1:0]         s1x_mag,
  output logic        [SW-1:0]         s1y_mag,
  output logic        [DW-1:0]         tn_mag,
  output logic        [DW-1:0]         den_mag
);

  function automatic logic signed [SW-1:0] sdiff(logic signed [CoordWidth-1:0] a,
                                                 logic signed [CoordWidth-1:0] b);
    return $signed({a[CoordWidth-1], a}) - $signed({b[CoordWidth-1], b});
  endfunction

  function automatic logic signed [DW-1:0] pdiff(logic signed [PW-1:0] a,
                                                 logic signed [PW-1:0] b);
    return $signed({a[PW-1], a}) - $signed({b[PW-1], b});
  endfunction

  // stage 1: deltas
  logic                 v1_r;
  logic signed [SW-1:0] s1x_r, s1y_r, s2x_r, s2y_r, dx_r, dy_r;
  item_t                it1_r;
  // stage 2: products
  logic                 v2_r;
  logic signed [PW-1:0] m_a_r, m_b_r, m_c_r, m_d_r, m_e_r, m_f_r;
  logic signed [SW-1:0] s1x2_r, s1y2_r;
  item_t                it2_r;
  // stage 3: cross-product sums
  logic                 v3_r;
  logic signed [DW-1:0] den_r, tn_r, sn_r;
  logic signed [SW-1:0] s1x3_r, s1y3_r;
  item_t                it3_r;
  // stage 4: normalized
  logic                 v4_r;
  item_t                it4_r;
  logic        [SW-1:0] s1x_mag_r, s1y_mag_r;
  logic        [DW-1:0] tn_mag_r, den_mag_r;

  logic                 den_neg;
  logic signed [DW-1:0] tn_n, sn_n, den_a;
  item_t                it4_nxt;

  always_comb begin
    den_neg = den_r[DW-1];
    tn_n    = den_neg ? -tn_r : tn_r;
    sn_n    = den_neg ? -sn_r : sn_r;
    den_a   = den_neg ? -den_r : den_r;
    it4_nxt = it3_r;
    it4_nxt.parallel = (den_r == '0);
    it4_nxt.on_both  = !tn_n[DW-1] && !sn_n[DW-1] &&
                       ($unsigned(tn_n) <= $unsigned(den_a)) &&
                       ($unsigned(sn_n) <= $unsigned(den_a)) && (den_r != '0);
    it4_nxt.neg_x    = s1x3_r[SW-1] ^ tn_n[DW-1];
    it4_nxt.neg_y    = s1y3_r[SW-1] ^ tn_n[DW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1x_r <= sdiff(fe_x, fs_x);
      s1y_r <= sdiff(fe_y, fs_y);
      s2x_r <= sdiff(se_x, ss_x);
      s2y_r <= sdiff(se_y, ss_y);
      dx_r  <= sdiff(fs_x, ss_x);
      dy_r  <= sdiff(fs_y, ss_y);
      it1_r <= '{p0x: fs_x, p0y: fs_y, z: hz, on_both: 1'b0, parallel: 1'b0,
                 neg_x: 1'b0, neg_y: 1'b0};

      m_a_r  <= s1x_r * s2y_r;
      m_b_r  <= s2x_r * s1y_r;
      m_c_r  <= s2x_r * dy_r;
      m_d_r  <= s2y_r * dx_r;
      m_e_r  <= s1x_r * dy_r;
      m_f_r  <= s1y_r * dx_r;
      s1x2_r <= s1x_r;
      s1y2_r <= s1y_r;
      it2_r  <= it1_r;

      den_r  <= pdiff(m_a_r, m_b_r);
      tn_r   <= pdiff(m_c_r, m_d_r);
      sn_r   <= pdiff(m_e_r, m_f_r);
      s1x3_r <= s1x2_r;
      s1y3_r <= s1y2_r;
      it3_r  <= it2_r;

      it4_r     <= it4_nxt;
      s1x_mag_r <= s1x3_r[SW-1] ? $unsigned(-s1x3_r) : $unsigned(s1x3_r);
      s1y_mag_r <= s1y3_r[SW-1] ? $unsigned(-s1y3_r) : $unsigned(s1y3_r);
      tn_mag_r  <= tn_n[DW-1] ? $unsigned(-tn_n) : $unsigned(tn_n);
      den_mag_r <= $unsigned(den_a);
    end
  end

  assign f_valid = v4_r;
  assign f_item  = it4_r;
  assign s1x_mag = s1x_mag_r;
  assign s1y_mag = s1y_mag_r;
  assign tn_mag  = tn_mag_r;
  assign den_mag = den_mag_r;

endmodule

// ===== src/ste_scale.sv =====
// wide numerator products, rounding bias and quotient range check
module ste_scale import ste_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           f_valid,
  input  item_t          f_item,
  input  logic [SW-1:0]  s1x_mag,
  input  logic [SW-1:0]  s1y_mag,
  input  logic [DW-1:0]  tn_mag,
  input  logic [DW-1:0]  den_mag,
  output logic           s_valid,
  output item_t          s_item,
  output logic [N2W-1:0] n2x,
  output logic [N2W-1:0] n2y,
  output logic [D2W-1:0] d2,
  output logic           ovx,
  output logic           ovy
);

  // stage 5: partial products
  logic             v5_r;
  item_t            it5_r;
  logic [SW+TL-1:0] plx_r, ply_r;
  logic [SW+TH-1:0] phx_r, phy_r;
  logic [DW-1:0]    den5_r;
  // stage 6: full magnitudes
  logic             v6_r;
  item_t            it6_r;
  logic [NM-1:0]    mx_r, my_r;
  logic [DW-1:0]    den6_r;
  // stage 7: 2|num| + |den| and 2|den|
  logic             v7_r;
  item_t            it7_r;
  logic [N2W-1:0]   n2x_r, n2y_r;
  logic [D2W-1:0]   d2_r;
  // stage 8: overflow against the coordinate range
  logic             v8_r;
  item_t            it8_r;
  logic [N2W-1:0]   n2x8_r, n2y8_r;
  logic [D2W-1:0]   d28_r;
  logic             ovx_r, ovy_r;

  logic [N2W-1:0]   d2_big;

  assign d2_big = N2W'({d2_r, {CoordWidth{1'b0}}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else if (en) begin
      v5_r <= f_valid;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      plx_r  <= (SW+TL)'(s1x_mag) * (SW+TL)'(tn_mag[TL-1:0]);
      ply_r  <= (SW+TL)'(s1y_mag) * (SW+TL)'(tn_mag[TL-1:0]);
      phx_r  <= (SW+TH)'(s1x_mag) * (SW+TH)'(tn_mag[DW-1:TL]);
      phy_r  <= (SW+TH)'(s1y_mag) * (SW+TH)'(tn_mag[DW-1:TL]);
      den5_r <= den_mag;
      it5_r  <= f_item;

      mx_r   <= NM'(plx_r) + NM'({phx_r, {TL{1'b0}}});
      my_r   <= NM'(ply_r) + NM'({phy_r, {TL{1'b0}}});
      den6_r <= den5_r;
      it6_r  <= it5_r;

      n2x_r  <= N2W'({mx_r, 1'b0}) + N2W'(den6_r);
      n2y_r  <= N2W'({my_r, 1'b0}) + N2W'(den6_r);
      d2_r   <= {den6_r, 1'b0};
      it7_r  <= it6_r;

      ovx_r  <= (n2x_r >= d2_big);
      ovy_r  <= (n2y_r >= d2_big);
      n2x8_r <= n2x_r;
      n2y8_r <= n2y_r;
      d28_r  <= d2_r;
      it8_r  <= it7_r;
    end
  end

  assign s_valid = v8_r;
  assign s_item  = it8_r;
  assign n2x     = n2x8_r;
  assign n2y     = n2y8_r;
  assign d2      = d28_r;
  assign ovx     = ovx_r;
  assign ovy     = ovy_r;

endmodule

// ===== src/ste_div.sv =====
// pipelined restoring divider, one quotient bit per stage, x and y lanes
module ste_div import ste_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  s_valid,
  input  item_t                 s_item,
  input  logic [N2W-1:0]        n2x,
  input  logic [N2W-1:0]        n2y,
  input  logic [D2W-1:0]        d2,
  input  logic                  ovx,
  input  logic                  ovy,
  output logic                  q_valid,
  output item_t                 q_item,
  output logic [CoordWidth-1:0] qx,
  output logic [CoordWidth-1:0] qy,
  output logic                  q_ovx,
  output logic                  q_ovy
);

  localparam int N = CoordWidth;

  // returns {quotient bit, new remainder}
  function automatic logic [RW:0] div_step(logic [RW-1:0] rem, logic nb,
                                           logic [D2W-1:0] dv);
    logic [RW:0] sh;
    logic [RW:0] df;
    sh = {rem, nb};
    df = sh - {1'b0, dv};
    if (sh >= {1'b0, dv}) begin
      return {1'b1, df[RW-1:0]};
    end
    return {1'b0, sh[RW-1:0]};
  endfunction

  logic          v_r   [N];
  item_t         it_r  [N];
  logic [RW-1:0] rx_r  [N];
  logic [RW-1:0] ry_r  [N];
  logic [N-1:0]  lx_r  [N];
  logic [N-1:0]  ly_r  [N];
  logic [N-1:0]  qx_r  [N];
  logic [N-1:0]  qy_r  [N];
  logic [D2W-1:0] d_r  [N];
  logic          ox_r  [N];
  logic          oy_r  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic          v_in, ox_in, oy_in;
    item_t         it_in;
    logic [RW-1:0] rx_in, ry_in;
    logic [N-1:0]  lx_in, ly_in, qx_in, qy_in;
    logic [D2W-1:0] d_in;
    logic [RW:0]   sx, sy;

    if (k == 0) begin : g_first
      assign v_in  = s_valid;
      assign it_in = s_item;
      assign rx_in = n2x[N+RW-1:N];
      assign ry_in = n2y[N+RW-1:N];
      assign lx_in = n2x[N-1:0];
      assign ly_in = n2y[N-1:0];
      assign qx_in = '0;
      assign qy_in = '0;
      assign d_in  = d2;
      assign ox_in = ovx;
      assign oy_in = ovy;
    end else begin : g_next
      assign v_in  = v_r[k-1];
      assign it_in = it_r[k-1];
      assign rx_in = rx_r[k-1];
      assign ry_in = ry_r[k-1];
      assign lx_in = lx_r[k-1];
      assign ly_in = ly_r[k-1];
      assign qx_in = qx_r[k-1];
      assign qy_in = qy_r[k-1];
      assign d_in  = d_r[k-1];
      assign ox_in = ox_r[k-1];
      assign oy_in = oy_r[k-1];
    end

    assign sx = div_step(rx_in, lx_in[N-1], d_in);
    assign sy = div_step(ry_in, ly_in[N-1], d_in);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        it_r[k] <= it_in;
        rx_r[k] <= sx[RW-1:0];
        ry_r[k] <= sy[RW-1:0];
        lx_r[k] <= {lx_in[N-2:0], 1'b0};
        ly_r[k] <= {ly_in[N-2:0], 1'b0};
        qx_r[k] <= {qx_in[N-2:0], sx[RW]};
        qy_r[k] <= {qy_in[N-2:0], sy[RW]};
        d_r[k]  <= d_in;
        ox_r[k] <= ox_in;
        oy_r[k] <= oy_in;
      end
    end
  end

  assign q_valid = v_r[N-1];
  assign q_item  = it_r[N-1];
  assign qx      = qx_r[N-1];
  assign qy      = qy_r[N-1];
  assign q_ovx   = ox_r[N-1];
  assign q_ovy   = oy_r[N-1];

endmodule

// ===== src/segment_trim_or_extend_core.sv =====
// top level: crossing point of two 2D segments, fully pipelined
// pipeline: front and scale stages, one divider stage per coordinate bit, output register
// throughput: one item per cycle; the whole pipe advances unless a result
//   sits in the output register under stall
// reset: synchronous active-low rst_n clears all valid bits; payload is not reset
module segment_trim_or_extend_core import ste_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [CoordWidth-1:0] in_first_start_x,
  input  logic signed [CoordWidth-1:0] in_first_start_y,
  input  logic signed [CoordWidth-1:0] in_first_end_x,
  input  logic signed [CoordWidth-1:0] in_first_end_y,
  input  logic signed [CoordWidth-1:0] in_second_start_x,
  input  logic signed [CoordWidth-1:0] in_second_start_y,
  input  logic signed [CoordWidth-1:0] in_second_end_x,
  input  logic signed [CoordWidth-1:0] in_second_end_y,
  input  logic signed [CoordWidth-1:0] in_height_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [CoordWidth-1:0] out_cross_x,
  output logic signed [CoordWidth-1:0] out_cross_y,
  output logic signed [CoordWidth-1:0] out_cross_z,
  output logic                         out_within_both,
  output logic                         out_parallel_flag,
  output logic                         out_saturated_flag
);

  // pipe moves whenever the output register is empty or being drained
  logic en;

  logic           f_valid;
  item_t          f_item;
  logic [SW-1:0]  s1x_mag, s1y_mag;
  logic [DW-1:0]  tn_mag, den_mag;

  logic           s_valid;
  item_t          s_item;
  logic [N2W-1:0] n2x, n2y;
  logic [D2W-1:0] d2;
  logic           ovx, ovy;

  logic                  q_valid;
  item_t                 q_item;
  logic [CoordWidth-1:0] qx, qy;
  logic                  q_ovx, q_ovy;

  logic                         out_valid_r;
  logic signed [CoordWidth-1:0] cx_r, cy_r, cz_r;
  logic                         within_r, parallel_r, sat_r;

  logic signed [CoordWidth-1:0] cx_nxt, cy_nxt;
  logic                         satx, saty;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  ste_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_valid(in_valid),
    .fs_x    (in_first_start_x),
    .fs_y    (in_first_start_y),
    .fe_x    (in_first_end_x),
    .fe_y    (in_first_end_y),
    .ss_x    (in_second_start_x),
    .ss_y    (in_second_start_y),
    .se_x    (in_second_end_x),
    .se_y    (in_second_end_y),
    .hz      (in_height_z),
    .f_valid (f_valid),
    .f_item  (f_item),
    .s1x_mag (s1x_mag),
    .s1y_mag (s1y_mag),
    .tn_mag  (tn_mag),
    .den_mag (den_mag)
  );

  ste_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .f_valid (f_valid),
    .f_item  (f_item),
    .s1x_mag (s1x_mag),
    .s1y_mag (s1y_mag),
    .tn_mag  (tn_mag),
    .den_mag (den_mag),
    .s_valid (s_valid),
    .s_item  (s_item),
    .n2x     (n2x),
    .n2y     (n2y),
    .d2      (d2),
    .ovx     (ovx),
    .ovy     (ovy)
  );

  ste_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .s_valid (s_valid),
    .s_item  (s_item),
    .n2x     (n2x),
    .n2y     (n2y),
    .d2      (d2),
    .ovx     (ovx),
    .ovy     (ovy),
    .q_valid (q_valid),
    .q_item  (q_item),
    .qx      (qx),
    .qy      (qy),
    .q_ovx   (q_ovx),
    .q_ovy   (q_ovy)
  );

  // p0 + signed rounded offset, clipped to the coordinate range
  function automatic logic [CoordWidth:0] place(logic signed [CoordWidth-1:0] p0,
                                                logic [CoordWidth-1:0] q,
                                                logic neg, logic ov);
    logic signed [XW-1:0] off;
    logic signed [XW-1:0] res;
    off = neg ? -$signed(XW'(q)) : $signed(XW'(q));
    res = $signed({{2{p0[CoordWidth-1]}}, p0}) + off;
    if (ov) begin
      return neg ? {1'b1, CoordMin[CoordWidth-1:0]} : {1'b1, CoordMax[CoordWidth-1:0]};
    end
    if (res > CoordMax) begin
      return {1'b1, CoordMax[CoordWidth-1:0]};
    end
    if (res < CoordMin) begin
      return {1'b1, CoordMin[CoordWidth-1:0]};
    end
    return {1'b0, res[CoordWidth-1:0]};
  endfunction

  always_comb begin
    {satx, cx_nxt} = place(q_item.p0x, qx, q_item.neg_x, q_ovx);
    {saty, cy_nxt} = place(q_item.p0y, qy, q_item.neg_y, q_ovy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= q_valid;
    end
  end

  // degenerate denominators force a zero point and clear the other flags
  always_ff @(posedge clk) begin
    if (en) begin
      cx_r       <= q_item.parallel ? '0 : cx_nxt;
      cy_r       <= q_item.parallel ? '0 : cy_nxt;
      cz_r       <= q_item.z;
      within_r   <= q_item.on_both && !q_item.parallel;
      parallel_r <= q_item.parallel;
      sat_r      <= !q_item.parallel && (satx || saty);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_cross_x        = cx_r;
  assign out_cross_y        = cy_r;
  assign out_cross_z        = cz_r;
  assign out_within_both    = within_r;
  assign out_parallel_flag  = parallel_r;
  assign out_saturated_flag = sat_r;

  // a parallel result carries a zero point and no other flag
  a_parallel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && parallel_r |-> cx_r == '0 && cy_r == '0 && !within_r && !sat_r)
    else $error("parallel result not cleared");

  // a clipped result sits on a range bound
  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && sat_r |->
      cx_r == CoordMax[CoordWidth-1:0] || cx_r == CoordMin[CoordWidth-1:0] ||
      cy_r == CoordMax[CoordWidth-1:0] || cy_r == CoordMin[CoordWidth-1:0])
    else $error("saturation flag without bound value");

  // input is only held off by a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r && out_stall)
    else $error("input stalled without output backpressure");

  // a held result keeps its point while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(cx_r) && $stable(cy_r))
    else $error("stalled result changed");

endmodule

// ===== test/tb_top.sv =====
// testbench for the segment crossing core: random and directed segment pairs, scoreboard check
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ste_pkg::*;

  localparam int NumRandom = 1900;
  localparam int CycleLimit = 600000;
  localparam int DrainCycles = 60;   // longer than the pipe is deep

  // one segment pair as it enters the block
  typedef struct {
    logic signed [CoordWidth-1:0] ax0, ay0, ax1, ay1;
    logic signed [CoordWidth-1:0] bx0, by0, bx1, by1;
    logic signed [CoordWidth-1:0] z;
  } seg_pair_t;

  // one crossing result as it leaves the block
  typedef struct {
    logic signed [CoordWidth-1:0] x, y, z;
    logic on_both, parallel, sat;
  } crossing_t;

  // exact-width scratch type, far wider than any product in the math
  typedef logic signed [191:0] big_t;

  class crossing_scoreboard;
    crossing_t pending_q[$];
    int n_checked;
    int n_errors;
    int n_parallel;
    int n_within;
    int n_sat;

    // p0 + round(s * tn / den), ties away from zero, den already positive
    function automatic big_t offset_point(big_t p0, big_t s, big_t tn, big_t den);
      big_t num, mag, q;
      num = s * tn;
      mag = (num < 0) ? -num : num;
      q = (2 * mag + den) / (2 * den);
      if (num < 0) q = -q;
      return p0 + q;
    endfunction

    function automatic logic signed [CoordWidth-1:0] clip(big_t v, ref logic sat);
      big_t hi, lo;
      hi = (big_t'(1) <<< (CoordWidth - 1)) - 1;
      lo = -(big_t'(1) <<< (CoordWidth - 1));
      if (v > hi) begin
        sat = 1'b1;
        return hi[CoordWidth-1:0];
      end
      if (v < lo) begin
        sat = 1'b1;
        return lo[CoordWidth-1:0];
      end
      return v[CoordWidth-1:0];
    endfunction

    function automatic crossing_t predict(seg_pair_t p);
      crossing_t r;
      big_t s1x, s1y, s2x, s2y, dx, dy, den, tn, sn;
      logic sat;
      s1x = big_t'(p.ax1) - big_t'(p.ax0);
      s1y = big_t'(p.ay1) - big_t'(p.ay0);
      s2x = big_t'(p.bx1) - big_t'(p.bx0);
      s2y = big_t'(p.by1) - big_t'(p.by0);
      dx = big_t'(p.ax0) - big_t'(p.bx0);
      dy = big_t'(p.ay0) - big_t'(p.by0);
      den = s1x * s2y - s2x * s1y;
      tn = s2x * dy - s2y * dx;
      sn = s1x * dy - s1y * dx;
      sat = 1'b0;
      r.z = p.z;
      if (den == 0) begin
        r.x = '0;
        r.y = '0;
        r.on_both = 1'b0;
        r.parallel = 1'b1;
        r.sat = 1'b0;
        return r;
      end
      if (den < 0) begin
        den = -den;
        tn = -tn;
        sn = -sn;
      end
      r.on_both = (tn >= 0) && (sn >= 0) && (tn <= den) && (sn <= den);
      r.x = clip(offset_point(big_t'(p.ax0), s1x, tn, den), sat);
      r.y = clip(offset_point(big_t'(p.ay0), s1y, tn, den), sat);
      r.parallel = 1'b0;
      r.sat = sat;
      return r;
    endfunction

    function void note_input(seg_pair_t p);
      crossing_t e;
      e = predict(p);
      pending_q.push_back(e);
      if (e.parallel) n_parallel++;
      if (e.on_both) n_within++;
      if (e.sat) n_sat++;
    endfunction

    function void check_result(crossing_t got);
      crossing_t e;
      if (pending_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("error: result with nothing pending x=%0d y=%0d",
                                     got.x, got.y);
        return;
      end
      e = pending_q.pop_front();
      n_checked++;
      if (got.x !== e.x || got.y !== e.y || got.z !== e.z || got.on_both !== e.on_both ||
          got.parallel !== e.parallel || got.sat !== e.sat) begin
        n_errors++;
        if (n_errors <= 10) begin
          $display("mismatch #%0d exp x=%0d y=%0d z=%0d w=%b p=%b s=%b", n_checked,
                   e.x, e.y, e.z, e.on_both, e.parallel, e.sat);
          $display("              got x=%0d y=%0d z=%0d w=%b p=%b s=%b",
                   got.x, got.y, got.z, got.on_both, got.parallel, got.sat);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CoordWidth-1:0] in_first_start_x = '0, in_first_start_y = '0;
  logic signed [CoordWidth-1:0] in_first_end_x = '0, in_first_end_y = '0;
  logic signed [CoordWidth-1:0] in_second_start_x = '0, in_second_start_y = '0;
  logic signed [CoordWidth-1:0] in_second_end_x = '0, in_second_end_y = '0;
  logic signed [CoordWidth-1:0] in_height_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [CoordWidth-1:0] out_cross_x, out_cross_y, out_cross_z;
  logic out_within_both, out_parallel_flag, out_saturated_flag;

  crossing_scoreboard sb = new();
  int cycle_count = 0;
  int n_sent = 0;

  always #5 clk = ~clk;

  segment_trim_or_extend_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_first_start_x(in_first_start_x), .in_first_start_y(in_first_start_y),
    .in_first_end_x(in_first_end_x), .in_first_end_y(in_first_end_y),
    .in_second_start_x(in_second_start_x), .in_second_start_y(in_second_start_y),
    .in_second_end_x(in_second_end_x), .in_second_end_y(in_second_end_y),
    .in_height_z(in_height_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_cross_x(out_cross_x), .out_cross_y(out_cross_y), .out_cross_z(out_cross_z),
    .out_within_both(out_within_both), .out_parallel_flag(out_parallel_flag),
    .out_saturated_flag(out_saturated_flag)
  );

  // watchdog: a hung pipe or a lost handshake ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d items still pending", cycle_count,
               sb.pending_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver stall: the pattern switches at random between
  // no stall, light stall and heavy stall
  int stall_mode = 0;
  always @(posedge clk) begin
    if (cycle_count % 150 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 1) == 0);
    endcase
  end

  // result monitor: values seen at the edge are the ones the edge accepts
  always @(posedge clk) begin
    crossing_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.x = out_cross_x;
      got.y = out_cross_y;
      got.z = out_cross_z;
      got.on_both = out_within_both;
      got.parallel = out_parallel_flag;
      got.sat = out_saturated_flag;
      sb.check_result(got);
    end
  end

  // drive one item and hold it until the block takes it
  task automatic send_item(seg_pair_t p);
    in_first_start_x <= p.ax0;
    in_first_start_y <= p.ay0;
    in_first_end_x <= p.ax1;
    in_first_end_y <= p.ay1;
    in_second_start_x <= p.bx0;
    in_second_start_y <= p.by0;
    in_second_end_x <= p.bx1;
    in_second_end_y <= p.by1;
    in_height_z <= p.z;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_input(p);
    n_sent++;
  endtask

  // close a burst with a random idle gap, possibly empty, bounded by max_gap
  task automatic idle_gap(int max_gap);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic seg_pair_t make_pair(int ax0, int ay0, int ax1, int ay1,
                                          int bx0, int by0, int bx1, int by1, int z);
    seg_pair_t p;
    p.ax0 = ax0; p.ay0 = ay0; p.ax1 = ax1; p.ay1 = ay1;
    p.bx0 = bx0; p.by0 = by0; p.bx1 = bx1; p.by1 = by1;
    p.z = z;
    return p;
  endfunction

  function automatic int small_coord();
    return int'($urandom_range(0, 2 * (1 << 20))) - (1 << 20);
  endfunction

  // random pair: full-range noise, small general segments, plus the corner shapes
  function automatic seg_pair_t random_pair();
    seg_pair_t p;
    int kind, kx, ky;
    kind = $urandom_range(0, 9);
    p.z = $urandom();
    case (kind)
      0, 1, 2: begin   // full-range noise
        p.ax0 = $urandom(); p.ay0 = $urandom(); p.ax1 = $urandom(); p.ay1 = $urandom();
        p.bx0 = $urandom(); p.by0 = $urandom(); p.bx1 = $urandom(); p.by1 = $urandom();
      end
      3: begin   // parallel: second is first shifted and rescaled
        p.ax0 = small_coord(); p.ay0 = small_coord();
        p.ax1 = small_coord(); p.ay1 = small_coord();
        kx = small_coord(); ky = small_coord();
        p.bx0 = p.ax0 + kx; p.by0 = p.ay0 + ky;
        p.bx1 = p.bx0 + 2 * (p.ax1 - p.ax0); p.by1 = p.by0 + 2 * (p.ay1 - p.ay0);
      end
      4: begin   // zero-length segment on one side
        p.ax0 = $urandom(); p.ay0 = $urandom(); p.ax1 = p.ax0; p.ay1 = p.ay0;
        p.bx0 = $urandom(); p.by0 = $urandom(); p.bx1 = $urandom(); p.by1 = $urandom();
      end
      5: begin   // vertical first, horizontal second
        p.ax0 = small_coord(); p.ay0 = small_coord(); p.ax1 = p.ax0; p.ay1 = small_coord();
        p.bx0 = small_coord(); p.by0 = small_coord(); p.bx1 = small_coord(); p.by1 = p.by0;
      end
      6: begin   // nearly parallel long segments, extension runs off the range
        p.ax0 = $urandom(); p.ay0 = $urandom();
        p.ax1 = p.ax0 + int'($urandom_range(1, 1 << 16)); p.ay1 = p.ay0 + 1;
        p.bx0 = p.ax0 + small_coord(); p.by0 = p.ay0 + small_coord();
        p.bx1 = p.bx0 + (p.ax1 - p.ax0) + 1; p.by1 = p.by0 + 1;
      end
      default: begin   // small general segments, crossing in or out
        p.ax0 = small_coord(); p.ay0 = small_coord(); p.ax1 = small_coord();
        p.ay1 = small_coord(); p.bx0 = small_coord(); p.by0 = small_coord();
        p.bx1 = small_coord(); p.by1 = small_coord();
      end
    endcase
    return p;
  endfunction

  initial begin
    seg_pair_t dir_q[$];
    int mx, mn, burst;
    mx = 32'h7fffffff;
    mn = 32'h80000000;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: crossing inside, crossing outside, vertical, parallel, collinear,
    // zero length, rounding ties, range extremes and saturation
    dir_q.push_back(make_pair(0, 0, 4 << 16, 4 << 16, 0, 4 << 16, 4 << 16, 0, 7));
    dir_q.push_back(make_pair(0, 0, 1 << 16, 1 << 16, 10 << 16, 0, 10 << 16, 1 << 16, -7));
    dir_q.push_back(make_pair(3 << 16, -5, 3 << 16, 5, -9, 0, 9, 0, 0));
    dir_q.push_back(make_pair(0, 0, 5, 5, 1, 0, 6, 5, 1));
    dir_q.push_back(make_pair(0, 0, 5, 5, 1, 1, 9, 9, 2));
    dir_q.push_back(make_pair(4, 4, 4, 4, 0, 0, 9, 3, 3));
    dir_q.push_back(make_pair(0, 0, 1, 0, 0, 0, 0, 0, 4));
    dir_q.push_back(make_pair(0, 0, 3, 1, 1, 0, 1, 1, 5));
    dir_q.push_back(make_pair(0, 0, -3, -1, -1, 0, -1, 1, 6));
    dir_q.push_back(make_pair(0, 0, 1, 0, 0, -1, 1, 1, 8));
    dir_q.push_back(make_pair(mx, mx, mx, mx, mx, mx, mx, mx, mx));
    dir_q.push_back(make_pair(mn, mn, mn, mn, mn, mn, mn, mn, mn));
    dir_q.push_back(make_pair(mn, mn, mx, mx, mn, mx, mx, mn, -1));
    dir_q.push_back(make_pair(mn, 0, mx, 0, 0, mn, 0, mx, mx));
    dir_q.push_back(make_pair(0, 0, 1, 0, mx, 0, mx, 1, mn));
    dir_q.push_back(make_pair(0, 0, -1, 0, mn, 0, mn, 1, 0));
    dir_q.push_back(make_pair(0, 0, 1, 1, 0, 1, mx, mx, 0));
    dir_q.push_back(make_pair(mx, 0, mx - 1, 0, mn, -1, mn, 1, 0));
    dir_q.push_back(make_pair(mn, mn, mn + 1, mn + 1, mx, mn, mx, mn + 1, 0));
    dir_q.push_back(make_pair(0, 0, 0, 1, mx, 0, mn, 1, -5));
    foreach (dir_q[i]) send_item(dir_q[i]);
    in_valid <= 1'b0;
    @(posedge clk);

    // random bursts; some bursts run back to back with no gaps
    while (n_sent < dir_q.size() + NumRandom) begin
      burst = $urandom_range(1, 40);
      repeat (burst) send_item(random_pair());
      idle_gap(($urandom_range(0, 3) == 0) ? 0 : 12);
    end
    in_valid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("sent %0d items, checked %0d results in %0d cycles", n_sent, sb.n_checked,
             cycle_count);
    $display("parallel %0d, within both %0d, saturated %0d, mismatches %0d",
             sb.n_parallel, sb.n_within, sb.n_sat, sb.n_errors);
    if (sb.n_errors == 0 && sb.pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
